// ----- hdl/cascade_position_speed_pid_assert.svh -----
// ----------------------------------------------------------------------------
// cascade_position_speed_pid_assert
// assertion macros shared by the cascade controller rtl
// ----------------------------------------------------------------------------
`ifndef CASCADE_POSITION_SPEED_PID_ASSERT_SVH
`define CASCADE_POSITION_SPEED_PID_ASSERT_SVH

// same-cycle implication, checked outside of reset
`define CPSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside of reset
`define CPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cpsp_pkg.sv -----
// ----------------------------------------------------------------------------
// cpsp_pkg
// shared types and constants of the cascade position / speed controller
// ----------------------------------------------------------------------------
`default_nettype none

package cpsp_pkg;

    // gain registers are signed q8.8
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_KP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_KI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_KD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPD_KP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPD_KI = 3'd4;

    // low-pass weights, 0.7 new and 0.3 old in 1/256 steps
    localparam logic signed [GAIN_W-1:0] FILT_NEW = 16'sd179;
    localparam logic signed [GAIN_W-1:0] FILT_OLD = 16'sd77;

    // parameter defaults
    localparam int DEF_DATA_WIDTH    = 16;
    localparam int DEF_POS_INT_LIMIT = 400;
    localparam int DEF_SPD_INT_LIMIT = 2000;

    typedef struct packed {
        logic signed [GAIN_W-1:0] pos_kp;
        logic signed [GAIN_W-1:0] pos_ki;
        logic signed [GAIN_W-1:0] pos_kd;
        logic signed [GAIN_W-1:0] spd_kp;
        logic signed [GAIN_W-1:0] spd_ki;
    } t_gains;

    // multiply-accumulate command: issue a product, first one of a sum
    typedef struct packed {
        logic issue;
        logic first;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ----- hdl/cpsp_ifs.sv -----
// ----------------------------------------------------------------------------
// cpsp_ifs
// valid / ready channels of the cascade controller: sample, drive, config
// ----------------------------------------------------------------------------
`default_nettype none

// sample channel
interface cpsp_in_if #(
    parameter int W = 16
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] measured_position;
    logic signed [W-1:0] cmd_position;
    logic signed [W-1:0] measured_speed;

    modport source (output valid, measured_position, cmd_position, measured_speed,
                    input ready);
    modport sink   (input valid, measured_position, cmd_position, measured_speed,
                    output ready);
endinterface

// drive channel
interface cpsp_out_if #(
    parameter int W = 16
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] drive_value;

    modport source (output valid, drive_value, input ready);
    modport sink   (input valid, drive_value, output ready);
endinterface

// register write channel
interface cpsp_cfg_if import cpsp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/cpsp_regs.sv -----
// ----------------------------------------------------------------------------
// cpsp_regs
// gain register file, written through the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module cpsp_regs import cpsp_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    cpsp_cfg_if.sink i_cfg,
    output t_gains  o_gains
);

    t_gains r_gains;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register write, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_POS_KP: r_gains.pos_kp <= i_cfg.data;
                REG_POS_KI: r_gains.pos_ki <= i_cfg.data;
                REG_POS_KD: r_gains.pos_kd <= i_cfg.data;
                REG_SPD_KP: r_gains.spd_kp <= i_cfg.data;
                REG_SPD_KI: r_gains.spd_ki <= i_cfg.data;
                default:    r_gains        <= r_gains;
            endcase
        end
    end

    assign o_gains = r_gains;

endmodule

`default_nettype wire

// ----- hdl/cpsp_mac.sv -----
// ----------------------------------------------------------------------------
// cpsp_mac
// shared multiply-accumulate unit: registered product, then accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module cpsp_mac import cpsp_pkg::*; #(
    parameter int B_W = 18
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire t_mac_ctl                        i_ctl,
    input  wire signed [GAIN_W-1:0]              i_a,
    input  wire signed [B_W-1:0]                 i_b,
    output logic signed [GAIN_W+B_W+2-1:0]       o_acc
);

    localparam int P_W   = GAIN_W + B_W;
    localparam int ACC_W = P_W + 2;

    logic signed [P_W-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;
    t_mac_ctl                r_ctl;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // accumulate stage, in the cycle after the product
    always_ff @(posedge i_clk) begin
        if (r_ctl.issue) begin
            if (r_ctl.first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ----- hdl/cascade_position_speed_pid.sv -----
// ----------------------------------------------------------------------------
// cascade_position_speed_pid
// cascade controller: position pid feeding a filtered speed pi, one drive
// value per sample, all products through one shared multiplier
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  i_in     in   valid / ready      measured_position, cmd_position,
//                                   measured_speed
//  o_out    out  valid / ready      drive_value
//  i_cfg    in   valid / ready      index, data (gain registers 0..4)
//
//  the drive value is produced by a sequence of steps after a sample is
//  accepted: seven products through the single multiply-accumulate unit,
//  a drain step after each sum, plus the integral and filter updates.
//  i_in.ready is high only while the sequencer is idle.
//  the drive value sits in an output register and the next sample is taken
//  while it waits; the sequencer holds in its last step if still not taken.
//  reset clears gains, loop state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module cascade_position_speed_pid import cpsp_pkg::*; #(
    parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
    parameter int POS_INT_LIMIT = DEF_POS_INT_LIMIT,
    parameter int SPD_INT_LIMIT = DEF_SPD_INT_LIMIT
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    cpsp_in_if.sink   i_in,
    cpsp_out_if.source o_out,
    cpsp_cfg_if.sink  i_cfg
);

`include "cascade_position_speed_pid_assert.svh"

    localparam int D       = DATA_WIDTH;
    localparam int PERR_W  = D + 1;
    localparam int PDIFF_W = D + 2;
    localparam int SERR_W  = D + 1;
    localparam int FILT_W  = D + 2;
    localparam int PI_W    = $clog2(POS_INT_LIMIT + 1) + 1;
    localparam int SI_W    = $clog2(SPD_INT_LIMIT + 1) + 1;
    localparam int SUMP_W  = ((PI_W > PERR_W) ? PI_W : PERR_W) + 1;
    localparam int SUMS_W  = ((SI_W > FILT_W) ? SI_W : FILT_W) + 1;
    localparam int MB_A    = (FILT_W > PI_W) ? FILT_W : PI_W;
    localparam int MB_W    = (MB_A > SI_W) ? MB_A : SI_W;
    localparam int ACC_W   = GAIN_W + MB_W + 2;
    localparam int Q_W     = ACC_W - 8;

    localparam logic signed [D-1:0]      DMAX    = {1'b0, {(D-1){1'b1}}};
    localparam logic signed [D-1:0]      DMIN    = {1'b1, {(D-1){1'b0}}};
    localparam logic signed [SUMP_W-1:0] PLIM_HI = SUMP_W'(POS_INT_LIMIT);
    localparam logic signed [SUMP_W-1:0] PLIM_LO = -PLIM_HI;
    localparam logic signed [SUMS_W-1:0] SLIM_HI = SUMS_W'(SPD_INT_LIMIT);
    localparam logic signed [SUMS_W-1:0] SLIM_LO = -SLIM_HI;

    // sequencer steps
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PINT = 4'd1;
    localparam logic [3:0] ST_M0   = 4'd2;
    localparam logic [3:0] ST_M1   = 4'd3;
    localparam logic [3:0] ST_M2   = 4'd4;
    localparam logic [3:0] ST_PW   = 4'd5;
    localparam logic [3:0] ST_SETP = 4'd6;
    localparam logic [3:0] ST_M3   = 4'd7;
    localparam logic [3:0] ST_M4   = 4'd8;
    localparam logic [3:0] ST_FW   = 4'd9;
    localparam logic [3:0] ST_FILT = 4'd10;
    localparam logic [3:0] ST_SINT = 4'd11;
    localparam logic [3:0] ST_M5   = 4'd12;
    localparam logic [3:0] ST_M6   = 4'd13;
    localparam logic [3:0] ST_SW   = 4'd14;
    localparam logic [3:0] ST_DRV  = 4'd15;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic signed [PERR_W-1:0]  r_perr;
    logic signed [PERR_W-1:0]  r_last;
    logic signed [PDIFF_W-1:0] r_pdiff;
    logic signed [PI_W-1:0]    r_pint;
    logic signed [D-1:0]       r_mspd;
    logic signed [SERR_W-1:0]  r_serr;
    logic signed [FILT_W-1:0]  r_filt;
    logic signed [SI_W-1:0]    r_sint;
    logic signed [D-1:0]       r_drive;
    logic                      r_ovalid;

    t_gains                    w_gains;
    t_mac_ctl                  w_ctl;
    logic signed [GAIN_W-1:0]  w_a;
    logic signed [MB_W-1:0]    w_b;
    logic signed [ACC_W-1:0]   w_acc;
    logic [ACC_W-1:0]          w_bias;
    logic signed [Q_W-1:0]     w_quot;
    logic signed [D-1:0]       w_sat;
    logic signed [SUMP_W-1:0]  w_psum;
    logic signed [SUMS_W-1:0]  w_ssum;
    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_pint_ok;
    logic                      w_sint_ok;
    logic                      w_drv_done;

    // gain registers
    cpsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_gains (w_gains)
    );

    // shared multiply-accumulate
    cpsp_mac #(
        .B_W (MB_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_acc   (w_acc)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;

    // operand selection per step
    always_comb begin
        w_ctl = '0;
        w_a   = '0;
        w_b   = '0;
        case (r_state)
            ST_M0: begin
                w_ctl = '{issue: 1'b1, first: 1'b1};
                w_a   = w_gains.pos_kp;
                w_b   = MB_W'(r_perr);
            end
            ST_M1: begin
                w_ctl = '{issue: 1'b1, first: 1'b0};
                w_a   = w_gains.pos_ki;
                w_b   = MB_W'(r_pint);
            end
            ST_M2: begin
                w_ctl = '{issue: 1'b1, first: 1'b0};
                w_a   = w_gains.pos_kd;
                w_b   = MB_W'(r_pdiff);
            end
            ST_M3: begin
                w_ctl = '{issue: 1'b1, first: 1'b1};
                w_a   = FILT_NEW;
                w_b   = MB_W'(r_serr);
            end
            ST_M4: begin
                w_ctl = '{issue: 1'b1, first: 1'b0};
                w_a   = FILT_OLD;
                w_b   = MB_W'(r_filt);
            end
            ST_M5: begin
                w_ctl = '{issue: 1'b1, first: 1'b1};
                w_a   = w_gains.spd_kp;
                w_b   = MB_W'(r_filt);
            end
            ST_M6: begin
                w_ctl = '{issue: 1'b1, first: 1'b0};
                w_a   = w_gains.spd_ki;
                w_b   = MB_W'(r_sint);
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // divide by 256 toward zero, then saturate to the data range
    assign w_bias = w_acc + (w_acc[ACC_W-1] ? ACC_W'(255) : '0);
    assign w_quot = w_bias[ACC_W-1:8];
    always_comb begin
        if (w_quot > Q_W'(DMAX)) begin
            w_sat = DMAX;
        end else if (w_quot < Q_W'(DMIN)) begin
            w_sat = DMIN;
        end else begin
            w_sat = w_quot[D-1:0];
        end
    end

    // integral sums before clamping
    assign w_psum = SUMP_W'(r_pint) + SUMP_W'(r_perr);
    assign w_ssum = SUMS_W'(r_sint) + SUMS_W'(r_filt);

    // step sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_PINT;
            ST_DRV:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = r_state + 4'd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // loop state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pint <= '0;
            r_last <= '0;
            r_filt <= '0;
            r_sint <= '0;
        end else begin
            case (r_state)
                ST_PINT: begin
                    if (w_psum > PLIM_HI) begin
                        r_pint <= PLIM_HI[PI_W-1:0];
                    end else if (w_psum < PLIM_LO) begin
                        r_pint <= PLIM_LO[PI_W-1:0];
                    end else begin
                        r_pint <= w_psum[PI_W-1:0];
                    end
                    r_last <= r_perr;
                end
                ST_FILT: r_filt <= w_quot[FILT_W-1:0];
                ST_SINT: begin
                    if (w_ssum > SLIM_HI) begin
                        r_sint <= SLIM_HI[SI_W-1:0];
                    end else if (w_ssum < SLIM_LO) begin
                        r_sint <= SLIM_LO[SI_W-1:0];
                    end else begin
                        r_sint <= w_ssum[SI_W-1:0];
                    end
                end
                default: r_pint <= r_pint;
            endcase
        end
    end

    // sample capture and intermediate terms
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_perr <= PERR_W'(i_in.cmd_position) - PERR_W'(i_in.measured_position);
            r_mspd <= i_in.measured_speed;
        end
        if (r_state == ST_PINT) begin
            r_pdiff <= PDIFF_W'(r_perr) - PDIFF_W'(r_last);
        end
        if (r_state == ST_SETP) begin
            r_serr <= SERR_W'(w_sat) - SERR_W'(r_mspd);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DRV && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DRV && w_out_free) begin
            r_drive <= w_sat;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.drive_value = r_drive;

    // checks
    assign w_pint_ok  = (SUMP_W'(r_pint) <= PLIM_HI) && (SUMP_W'(r_pint) >= PLIM_LO);
    assign w_sint_ok  = (SUMS_W'(r_sint) <= SLIM_HI) && (SUMS_W'(r_sint) >= SLIM_LO);
    assign w_drv_done = (r_state == ST_DRV) && w_out_free;

    `CPSP_ASSERT_NOW(a_pint_range, i_clk, i_rst_n, 1'b1, w_pint_ok, "position integral range")
    `CPSP_ASSERT_NOW(a_sint_range, i_clk, i_rst_n, 1'b1, w_sint_ok, "speed integral range")
    `CPSP_ASSERT_NEXT(a_accept_seq, i_clk, i_rst_n, w_in_acc, (r_state == ST_PINT), "no start")
    `CPSP_ASSERT_NEXT(a_drive_out, i_clk, i_rst_n, w_drv_done, o_out.valid, "drive not presented")

endmodule

`default_nettype wire

// ----- dv/cpsp_drive_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsp_drive_checker
// watches the sample, drive and register channels of the cascade controller,
// predicts each drive value from its own copy of gains and loop state, and
// compares every drive transaction with the oldest predicted value
// ----------------------------------------------------------------------------

module cpsp_drive_checker import cpsp_pkg::*; #(
    parameter int POS_LIMIT = DEF_POS_INT_LIMIT,
    parameter int SPD_LIMIT = DEF_SPD_INT_LIMIT
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    cpsp_in_if   in_ch,
    cpsp_out_if  out_ch,
    cpsp_cfg_if  cfg_ch,
    output int   o_pending,
    output int   o_errors
);

    // gains as last written
    logic signed [GAIN_W-1:0] g_pos_kp, g_pos_ki, g_pos_kd, g_spd_kp, g_spd_ki;

    // loop state
    logic signed [9:0]  pos_integral;
    logic signed [16:0] last_pos_err;
    logic signed [17:0] filt_spd_err;
    logic signed [11:0] spd_integral;

    logic signed [15:0] drive_q[$];
    logic signed [15:0] want_drive;
    int                 err_count;

    function automatic logic signed [39:0] clamp_to(input logic signed [39:0] v, input int lim);
        if (v > lim)
            return 40'(lim);
        if (v < -lim)
            return 40'(-lim);
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767)
            return 16'sh7fff;
        if (v < -40'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // one sample through the position pid and the filtered speed pi
    function automatic logic signed [15:0] next_drive(input logic signed [15:0] mpos,
                                                      input logic signed [15:0] tpos,
                                                      input logic signed [15:0] mspd);
        logic signed [16:0] perr;
        logic signed [19:0] pacc;
        logic signed [39:0] psum;
        logic signed [15:0] setpoint;
        logic signed [16:0] serr;
        logic signed [31:0] fsum;
        logic signed [17:0] filt;
        logic signed [19:0] sacc;
        logic signed [39:0] ssum;
        perr = 17'(tpos) - 17'(mpos);
        pacc = 20'(pos_integral) + 20'(perr);
        pos_integral = 10'(clamp_to(40'(pacc), POS_LIMIT));
        psum = 40'(g_pos_kp) * 40'(perr) + 40'(g_pos_ki) * 40'(pos_integral)
             + 40'(g_pos_kd) * (40'(perr) - 40'(last_pos_err));
        last_pos_err = perr;
        setpoint = sat16(psum / 40'sd256);

        serr = 17'(setpoint) - 17'(mspd);
        fsum = 32'(FILT_NEW) * 32'(serr) + 32'(FILT_OLD) * 32'(filt_spd_err);
        filt = 18'(fsum / 32'sd256);
        filt_spd_err = filt;
        sacc = 20'(spd_integral) + 20'(filt);
        spd_integral = 12'(clamp_to(40'(sacc), SPD_LIMIT));
        ssum = 40'(g_spd_kp) * 40'(filt) + 40'(g_spd_ki) * 40'(spd_integral);
        return sat16(ssum / 40'sd256);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            g_pos_kp     = '0;
            g_pos_ki     = '0;
            g_pos_kd     = '0;
            g_spd_kp     = '0;
            g_spd_ki     = '0;
            pos_integral = '0;
            last_pos_err = '0;
            filt_spd_err = '0;
            spd_integral = '0;
            drive_q.delete();
            err_count    = 0;
        end else begin
            // register write transaction, unknown indexes change nothing
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_POS_KP: g_pos_kp = cfg_ch.data;
                    REG_POS_KI: g_pos_ki = cfg_ch.data;
                    REG_POS_KD: g_pos_kd = cfg_ch.data;
                    REG_SPD_KP: g_spd_kp = cfg_ch.data;
                    REG_SPD_KI: g_spd_ki = cfg_ch.data;
                    default: ;
                endcase
            end

            // sample transaction
            if (in_ch.valid && in_ch.ready)
                drive_q.push_back(next_drive(in_ch.measured_position, in_ch.cmd_position,
                                             in_ch.measured_speed));

            // drive transaction against the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                if (drive_q.size() == 0) begin
                    $error("drive_value: unexpected transaction, expected none, actual %0d",
                           out_ch.drive_value);
                    err_count++;
                end else begin
                    want_drive = drive_q.pop_front();
                    if (out_ch.drive_value !== want_drive) begin
                        $error("drive_value mismatch: expected %0d, actual %0d",
                               want_drive, out_ch.drive_value);
                        err_count++;
                    end
                end
            end
        end
        o_pending <= drive_q.size();
        o_errors  <= err_count;
    end

endmodule

// ----- dv/tb_cascade_position_speed_pid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cascade_position_speed_pid
// drives samples and gain writes into the cascade controller with random
// gaps and output stalls; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------

module tb_cascade_position_speed_pid;
    import cpsp_pkg::*;

    typedef enum {GAIN_SMALL, GAIN_FULL, GAIN_EXTREME} t_gain_mix;

    logic clk;
    logic rst_n;
    bit   calm;
    int   pending;
    int   errors;

    cpsp_in_if  #(.W(16)) in_ch ();
    cpsp_out_if #(.W(16)) out_ch ();
    cpsp_cfg_if           cfg_ch ();

    cascade_position_speed_pid dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    cpsp_drive_checker chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_ch    (cfg_ch),
        .o_pending (pending),
        .o_errors  (errors)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // drive side stalls
    initial out_ch.ready = 1'b0;
    always @(posedge clk) begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 38);
    end

    // run limit
    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    // write all five gains, then optionally the unused indexes
    task automatic load_gains(input t_gains g, input bit spare);
        t_gains cur;
        cur = g;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_POS_KP;
        cfg_ch.data  <= cur.pos_kp;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_POS_KI;
        cfg_ch.data  <= cur.pos_ki;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_POS_KD;
        cfg_ch.data  <= cur.pos_kd;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_SPD_KP;
        cfg_ch.data  <= cur.spd_kp;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_SPD_KI;
        cfg_ch.data  <= cur.spd_ki;
        do @(posedge clk); while (!cfg_ch.ready);
        if (spare) begin
            for (int i = REG_SPD_KI + 1; i < (1 << CFG_IDX_W); i++) begin
                cfg_ch.index <= CFG_IDX_W'(i);
                cfg_ch.data  <= 16'($urandom);
                do @(posedge clk); while (!cfg_ch.ready);
            end
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // one sample transaction after a random gap
    task automatic send_sample(input logic [15:0] mpos, input logic [15:0] tpos,
                               input logic [15:0] mspd);
        while (!calm && $urandom_range(0, 99) < 38) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.measured_position <= mpos;
        in_ch.cmd_position      <= tpos;
        in_ch.measured_speed    <= mspd;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // hold samples back until every drive value is out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [15:0] pick_gain(input t_gain_mix mix);
        case (mix)
            GAIN_SMALL: return 16'($urandom_range(0, 1024) - 512);
            GAIN_FULL:  return 16'($urandom);
            default: begin
                case ($urandom_range(0, 2))
                    0:       return 16'h7fff;
                    1:       return 16'h8000;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    // mostly tracking near a target with slow bias changes, some raw noise
    task automatic run_random(input int count, input int spread);
        logic [15:0] tgt;
        int          bias;
        int          off;
        int          spd;
        tgt  = 16'($urandom);
        bias = 0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 75) begin
                if ($urandom_range(0, 19) == 0)
                    tgt = 16'($urandom);
                if ($urandom_range(0, 19) == 0)
                    bias = int'($urandom_range(0, 2 * spread)) - spread;
                off = bias + int'($urandom_range(0, spread)) - spread / 2;
                spd = int'($urandom_range(0, spread)) - spread / 2;
                send_sample(16'(tgt + off), tgt, 16'(spd));
            end else begin
                send_sample(16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        t_gains    g;
        int        spread;
        rst_n                   = 1'b0;
        calm                    = 1'b0;
        in_ch.valid             = 1'b0;
        in_ch.measured_position = '0;
        in_ch.cmd_position      = '0;
        in_ch.measured_speed    = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_POS_KP;
        cfg_ch.data             = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gains at reset value
        send_sample(16'sd100, -16'sd200, 16'sd5);
        send_sample(16'sh8000, 16'sh7fff, 16'sh7fff);
        wait_drained();

        // moderate gains, spare indexes written to check they are ignored
        g = '{pos_kp: 16'sd256, pos_ki: 16'sd32, pos_kd: 16'sd128,
              spd_kp: 16'sd384, spd_ki: 16'sd24};
        load_gains(g, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        // position error at its extremes, integral clamps high then low
        send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff, 16'sh0000);
        send_sample(16'sh0000, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000, 16'sh0000);
        // sign flips stress the filter and derivative
        send_sample(16'sd1, -16'sd1, 16'sd1);
        send_sample(-16'sd1, 16'sd1, -16'sd1);
        send_sample(16'sd10, 16'sd12, 16'sd0);
        send_sample(16'sd12, 16'sd12, 16'sd0);
        wait_drained();

        // largest gains, drive saturates
        g = '{pos_kp: 16'sh7fff, pos_ki: 16'sh7fff, pos_kd: 16'sh7fff,
              spd_kp: 16'sh7fff, spd_ki: 16'sh7fff};
        load_gains(g, 1'b0);
        send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_sample(16'sd3, 16'sd3, 16'sd0);
        wait_drained();

        // most negative gains
        g = '{pos_kp: 16'sh8000, pos_ki: 16'sh8000, pos_kd: 16'sh8000,
              spd_kp: 16'sh8000, spd_ki: 16'sh8000};
        load_gains(g, 1'b0);
        send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_sample(-16'sd3, 16'sd0, 16'sd2);

        // random phases, one of them with no idling on either side
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            g.pos_kp = pick_gain(t_gain_mix'(p % 3));
            g.pos_ki = pick_gain(t_gain_mix'(p % 3));
            g.pos_kd = pick_gain(t_gain_mix'(p % 3));
            g.spd_kp = pick_gain(t_gain_mix'(p % 3));
            g.spd_ki = pick_gain(t_gain_mix'(p % 3));
            load_gains(g, p == 3);
            calm = (p == 5);
            case ($urandom_range(0, 3))
                0:       spread = 8;
                1:       spread = 64;
                2:       spread = 512;
                default: spread = 4096;
            endcase
            run_random(85, spread);
        end
        calm = 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
